// ----- hdl/tqm_pkg.sv -----
// Shared types, codes and field widths of the timer queue manager.
`default_nettype none

package tqm_pkg;

   localparam int CMD_W       = 2;
   localparam int TIME_W      = 48;
   localparam int IVL_W       = 32;
   localparam int TAG_W       = 16;
   localparam int STATUS_W    = 3;
   localparam int SLOT_OUT_W  = 4;
   localparam int MAX_EXPIRED = 16;
   localparam int ORDER_W     = $clog2(MAX_EXPIRED);
   localparam int NCNT_W      = ORDER_W + 1;

   typedef logic [CMD_W-1:0] cmd_type;

   localparam cmd_type CMD_ADD    = 2'd0;
   localparam cmd_type CMD_CANCEL = 2'd1;
   localparam cmd_type CMD_TICK   = 2'd2;

   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type ST_ADDED     = 3'd0;
   localparam status_type ST_FULL      = 3'd1;
   localparam status_type ST_CANCELLED = 3'd2;
   localparam status_type ST_NOT_FOUND = 3'd3;
   localparam status_type ST_EXPIRED   = 3'd4;
   localparam status_type ST_TICK_DONE = 3'd5;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      S_ADD_SCAN,
      S_ADD_RESULT,
      S_CAN_READ,
      S_CAN_CHECK,
      S_CAN_SCAN,
      S_CAN_RESULT,
      S_TK_SCAN,
      S_TK_PICK,
      S_TK_NEXT,
      S_TK_APPLY_RD,
      S_TK_APPLY_WR,
      S_TK_MIN,
      S_TK_EMIT_RD,
      S_TK_EMIT,
      S_TK_DONE
   } state_type;

   typedef enum logic [1:0] {
      RD_SCAN,
      RD_CANCEL,
      RD_ORDER
   } rd_sel_type;

   typedef enum logic [1:0] {
      RSP_ADD,
      RSP_CANCEL,
      RSP_EXPIRED,
      RSP_DONE
   } rsp_kind_type;

   typedef struct packed {
      logic         capture;
      logic         scan_req;
      logic         scan_due;
      rd_sel_type   rd_sel;
      logic         add_commit;
      logic         cancel_check;
      logic         tick_init;
      logic         pick;
      logic         k_clear;
      logic         k_inc;
      logic         apply_wr;
      logic         rsp_load;
      rsp_kind_type rsp_kind;
   } dp_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    scan_done;
      logic    due_found;
      logic    n_zero;
      logic    n_max;
      logic    k_last;
      logic    out_free;
   } dp_sts_type;

endpackage

`default_nettype wire

// ----- hdl/timer_queue_manager_unit.sv -----
// Top level of the timer queue manager: sequencer plus slot datapath.
//
// The block keeps a table of SLOTS timer slots. Each item on the req_ channel
// is one command: add a timer (expiry and repeat interval), cancel a timer
// (slot and tag), or tick with the current time. Each of these yields one or
// more items on the rsp_ channel; rsp_last marks the final one. A tick yields
// one expired item per due timer, in expiry order with ties to the lower slot,
// at most sixteen per tick, and then a tick-done item. Every result carries the
// earliest pending expiry after the whole command has been applied.
//
// Commands are handled one at a time; req_ready is high only while the block
// is idle. Timing is set by the slot scanner, which reads one slot per cycle
// from the slot tables' single read port. Each due timer of a tick is found
// by its own scan. The next command can be taken in the cycle after the last
// result of the previous one has been loaded.
//
// Reset clears all slots and the tag counter; no clearing pass is needed.
// If the receiver stalls, the result register holds its item and the block
// waits before loading the next one; a new command may be accepted while the
// last result of the previous one still waits.
`default_nettype none

module timer_queue_manager_unit #(
   parameter int SLOTS = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [tqm_pkg::CMD_W-1:0]       req_command,
   input  wire logic [tqm_pkg::TIME_W-1:0]      req_expiry_time,
   input  wire logic [tqm_pkg::IVL_W-1:0]       req_repeat_interval,
   input  wire logic [tqm_pkg::SLOT_OUT_W-1:0]  req_cancel_slot,
   input  wire logic [tqm_pkg::TAG_W-1:0]       req_cancel_tag,
   input  wire logic [tqm_pkg::TIME_W-1:0]      req_now_time,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [tqm_pkg::STATUS_W-1:0]         rsp_status,
   output logic [tqm_pkg::SLOT_OUT_W-1:0]       rsp_slot,
   output logic [tqm_pkg::TAG_W-1:0]            rsp_tag,
   output logic                                 rsp_rearmed,
   output logic                                 rsp_earliest_changed,
   output logic                                 rsp_next_valid,
   output logic [tqm_pkg::TIME_W-1:0]           rsp_next_expiry,
   output logic                                 rsp_last
);

   // Commands from the sequencer and status back from the datapath.
   tqm_pkg::dp_cmd_type dp_cmd;
   tqm_pkg::dp_sts_type dp_sts;

   tqm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (dp_sts),
      .cmd       (dp_cmd)
   );

   tqm_dp #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .req_command          (req_command),
      .req_expiry_time      (req_expiry_time),
      .req_repeat_interval  (req_repeat_interval),
      .req_cancel_slot      (req_cancel_slot),
      .req_cancel_tag       (req_cancel_tag),
      .req_now_time         (req_now_time),
      .cmd                  (dp_cmd),
      .sts                  (dp_sts),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_slot             (rsp_slot),
      .rsp_tag              (rsp_tag),
      .rsp_rearmed          (rsp_rearmed),
      .rsp_earliest_changed (rsp_earliest_changed),
      .rsp_next_valid       (rsp_next_valid),
      .rsp_next_expiry      (rsp_next_expiry),
      .rsp_last             (rsp_last)
   );

endmodule

`default_nettype wire

// ----- hdl/tqm_ctrl.sv -----
// Command sequencer of the timer queue manager.
`default_nettype none

module tqm_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire tqm_pkg::dp_sts_type sts,
   output tqm_pkg::dp_cmd_type     cmd
);

   tqm_pkg::state_type state_ff;
   tqm_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tqm_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tqm_pkg::S_IDLE: begin
            if (req_valid) state_in = tqm_pkg::S_DISPATCH;
         end
         tqm_pkg::S_DISPATCH: begin
            case (sts.cmd)
               tqm_pkg::CMD_ADD:    state_in = tqm_pkg::S_ADD_SCAN;
               tqm_pkg::CMD_CANCEL: state_in = tqm_pkg::S_CAN_READ;
               tqm_pkg::CMD_TICK:   state_in = tqm_pkg::S_TK_SCAN;
               default:             state_in = tqm_pkg::S_IDLE;
            endcase
         end
         tqm_pkg::S_ADD_SCAN: begin
            if (sts.scan_done) state_in = tqm_pkg::S_ADD_RESULT;
         end
         tqm_pkg::S_ADD_RESULT: begin
            if (sts.out_free) state_in = tqm_pkg::S_IDLE;
         end
         tqm_pkg::S_CAN_READ:  state_in = tqm_pkg::S_CAN_CHECK;
         tqm_pkg::S_CAN_CHECK: state_in = tqm_pkg::S_CAN_SCAN;
         tqm_pkg::S_CAN_SCAN: begin
            if (sts.scan_done) state_in = tqm_pkg::S_CAN_RESULT;
         end
         tqm_pkg::S_CAN_RESULT: begin
            if (sts.out_free) state_in = tqm_pkg::S_IDLE;
         end
         tqm_pkg::S_TK_SCAN: begin
            if (sts.scan_done) state_in = tqm_pkg::S_TK_PICK;
         end
         tqm_pkg::S_TK_PICK: state_in = tqm_pkg::S_TK_NEXT;
         tqm_pkg::S_TK_NEXT: begin
            if (sts.due_found && !sts.n_max) begin
               state_in = tqm_pkg::S_TK_SCAN;
            end else if (sts.n_zero) begin
               state_in = tqm_pkg::S_TK_MIN;
            end else begin
               state_in = tqm_pkg::S_TK_APPLY_RD;
            end
         end
         tqm_pkg::S_TK_APPLY_RD: state_in = tqm_pkg::S_TK_APPLY_WR;
         tqm_pkg::S_TK_APPLY_WR: begin
            state_in = sts.k_last ? tqm_pkg::S_TK_MIN : tqm_pkg::S_TK_APPLY_RD;
         end
         tqm_pkg::S_TK_MIN: begin
            if (sts.scan_done) begin
               state_in = sts.n_zero ? tqm_pkg::S_TK_DONE : tqm_pkg::S_TK_EMIT_RD;
            end
         end
         tqm_pkg::S_TK_EMIT_RD: state_in = tqm_pkg::S_TK_EMIT;
         tqm_pkg::S_TK_EMIT: begin
            if (sts.out_free) begin
               state_in = sts.k_last ? tqm_pkg::S_TK_DONE : tqm_pkg::S_TK_EMIT_RD;
            end
         end
         tqm_pkg::S_TK_DONE: begin
            if (sts.out_free) state_in = tqm_pkg::S_IDLE;
         end
         default: state_in = tqm_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.rd_sel   = tqm_pkg::RD_SCAN;
      cmd.rsp_kind = tqm_pkg::RSP_DONE;
      req_ready    = 1'b0;
      unique case (state_ff)
         tqm_pkg::S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         tqm_pkg::S_DISPATCH: begin
            cmd.tick_init = (sts.cmd == tqm_pkg::CMD_TICK);
         end
         tqm_pkg::S_ADD_SCAN: begin
            cmd.scan_req = 1'b1;
         end
         tqm_pkg::S_ADD_RESULT: begin
            cmd.add_commit = sts.out_free;
            cmd.rsp_load   = sts.out_free;
            cmd.rsp_kind   = tqm_pkg::RSP_ADD;
         end
         tqm_pkg::S_CAN_READ: begin
            cmd.rd_sel = tqm_pkg::RD_CANCEL;
         end
         tqm_pkg::S_CAN_CHECK: begin
            cmd.rd_sel       = tqm_pkg::RD_CANCEL;
            cmd.cancel_check = 1'b1;
         end
         tqm_pkg::S_CAN_SCAN: begin
            cmd.scan_req = 1'b1;
         end
         tqm_pkg::S_CAN_RESULT: begin
            cmd.rsp_load = sts.out_free;
            cmd.rsp_kind = tqm_pkg::RSP_CANCEL;
         end
         tqm_pkg::S_TK_SCAN: begin
            cmd.scan_req = 1'b1;
            cmd.scan_due = 1'b1;
         end
         tqm_pkg::S_TK_PICK: begin
            cmd.pick = sts.due_found;
         end
         tqm_pkg::S_TK_NEXT: begin
            cmd.k_clear = 1'b1;
         end
         tqm_pkg::S_TK_APPLY_RD: begin
            cmd.rd_sel = tqm_pkg::RD_ORDER;
         end
         tqm_pkg::S_TK_APPLY_WR: begin
            cmd.rd_sel   = tqm_pkg::RD_ORDER;
            cmd.apply_wr = 1'b1;
            cmd.k_inc    = !sts.k_last;
         end
         tqm_pkg::S_TK_MIN: begin
            cmd.scan_req = 1'b1;
            cmd.k_clear  = 1'b1;
         end
         tqm_pkg::S_TK_EMIT_RD: begin
            cmd.rd_sel = tqm_pkg::RD_ORDER;
         end
         tqm_pkg::S_TK_EMIT: begin
            cmd.rd_sel   = tqm_pkg::RD_ORDER;
            cmd.rsp_load = sts.out_free;
            cmd.rsp_kind = tqm_pkg::RSP_EXPIRED;
            cmd.k_inc    = sts.out_free && !sts.k_last;
         end
         tqm_pkg::S_TK_DONE: begin
            cmd.rsp_load = sts.out_free;
            cmd.rsp_kind = tqm_pkg::RSP_DONE;
         end
         default: begin
            cmd.rd_sel = tqm_pkg::RD_SCAN;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- hdl/tqm_dp.sv -----
// Slot tables, slot scanner, expiry order list and result register.
`default_nettype none

module tqm_dp #(
   parameter int SLOTS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [tqm_pkg::CMD_W-1:0]           req_command,
   input  wire logic [tqm_pkg::TIME_W-1:0]          req_expiry_time,
   input  wire logic [tqm_pkg::IVL_W-1:0]           req_repeat_interval,
   input  wire logic [tqm_pkg::SLOT_OUT_W-1:0]      req_cancel_slot,
   input  wire logic [tqm_pkg::TAG_W-1:0]           req_cancel_tag,
   input  wire logic [tqm_pkg::TIME_W-1:0]          req_now_time,
   input  wire tqm_pkg::dp_cmd_type                 cmd,
   output tqm_pkg::dp_sts_type                      sts,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [tqm_pkg::STATUS_W-1:0]             rsp_status,
   output logic [tqm_pkg::SLOT_OUT_W-1:0]           rsp_slot,
   output logic [tqm_pkg::TAG_W-1:0]                rsp_tag,
   output logic                                     rsp_rearmed,
   output logic                                     rsp_earliest_changed,
   output logic                                     rsp_next_valid,
   output logic [tqm_pkg::TIME_W-1:0]               rsp_next_expiry,
   output logic                                     rsp_last
);

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CS_W   = ((SLOT_W > tqm_pkg::SLOT_OUT_W) ? SLOT_W : tqm_pkg::SLOT_OUT_W) + 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
   localparam logic [tqm_pkg::TIME_W-1:0] TIME_MAX = '1;

   // Captured command fields.
   tqm_pkg::cmd_type                 cmd_ff;
   logic [tqm_pkg::TIME_W-1:0]       add_exp_ff;
   logic [tqm_pkg::IVL_W-1:0]        add_ivl_ff;
   logic [tqm_pkg::SLOT_OUT_W-1:0]   cslot_ff;
   logic [tqm_pkg::TAG_W-1:0]        ctag_ff;
   logic [tqm_pkg::TIME_W-1:0]       now_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff     <= req_command;
         add_exp_ff <= req_expiry_time;
         add_ivl_ff <= req_repeat_interval;
         cslot_ff   <= req_cancel_slot;
         ctag_ff    <= req_cancel_tag;
         now_ff     <= req_now_time;
      end
   end

   // Slot tables.
   logic [tqm_pkg::TIME_W-1:0] exp_mem [SLOTS];
   logic [tqm_pkg::IVL_W-1:0]  ivl_mem [SLOTS];
   logic [tqm_pkg::TAG_W-1:0]  tag_mem [SLOTS];
   logic [tqm_pkg::TIME_W-1:0] exp_rd_ff;
   logic [tqm_pkg::IVL_W-1:0]  ivl_rd_ff;
   logic [tqm_pkg::TAG_W-1:0]  tag_rd_ff;

   logic [SLOTS-1:0] valid_ff;
   logic [SLOTS-1:0] valid_in;
   logic [SLOTS-1:0] chosen_ff;
   logic [tqm_pkg::TAG_W-1:0] tag_ctr_ff;

   // Scanner: one slot read per cycle, evaluated in the cycle after its read.
   logic              scan_run_ff;
   logic [SLOT_W-1:0] scan_idx_ff;
   logic              pv_ff;
   logic [SLOT_W-1:0] pidx_ff;
   logic              scan_start;
   logic              scan_done;

   logic                        best_any_ff, best_any_in;
   logic [tqm_pkg::TIME_W-1:0]  best_val_ff, best_val_in;
   logic [SLOT_W-1:0]           best_idx_ff, best_idx_in;
   logic                        free_any_ff, free_any_in;
   logic [SLOT_W-1:0]           free_idx_ff, free_idx_in;
   logic                        cand;

   // Expiry order list of the current tick.
   logic [SLOT_W-1:0]              order_ff [tqm_pkg::MAX_EXPIRED];
   logic [tqm_pkg::NCNT_W-1:0]     n_ff;
   logic [tqm_pkg::ORDER_W-1:0]    k_ff;
   logic [SLOT_W-1:0]              order_slot;

   logic [CS_W-1:0]   cs_ext;
   logic              cs_in_range;
   logic [SLOT_W-1:0] cidx;
   logic              hit_ff;
   logic              hit;

   logic [SLOT_W-1:0]            rd_addr;
   logic [SLOT_W-1:0]            wr_addr;
   logic                         exp_we;
   logic                         add_we;
   logic [tqm_pkg::TIME_W-1:0]   exp_wdata;
   logic                         periodic;
   logic [tqm_pkg::TIME_W:0]     rearm_sum;
   logic [tqm_pkg::TIME_W-1:0]   rearm_val;
   logic                         add_early;
   logic [tqm_pkg::TIME_W-1:0]   add_next;

   assign order_slot  = order_ff[k_ff];
   assign cs_ext      = CS_W'(cslot_ff);
   assign cs_in_range = cs_ext < CS_W'(SLOTS);
   assign cidx        = cs_ext[SLOT_W-1:0];
   assign hit         = cs_in_range && valid_ff[cidx] && (tag_rd_ff == ctag_ff);
   assign periodic    = ivl_rd_ff != '0;
   assign rearm_sum   = {1'b0, now_ff} + (tqm_pkg::TIME_W + 1)'(ivl_rd_ff);
   assign rearm_val   = rearm_sum[tqm_pkg::TIME_W] ? TIME_MAX
                                                   : rearm_sum[tqm_pkg::TIME_W-1:0];
   assign add_early   = !best_any_ff || (add_exp_ff < best_val_ff);
   assign add_next    = add_early ? add_exp_ff : best_val_ff;

   always_comb begin
      unique case (cmd.rd_sel)
         tqm_pkg::RD_SCAN:   rd_addr = scan_idx_ff;
         tqm_pkg::RD_CANCEL: rd_addr = cidx;
         tqm_pkg::RD_ORDER:  rd_addr = order_slot;
         default:            rd_addr = scan_idx_ff;
      endcase
   end

   assign add_we    = cmd.add_commit && free_any_ff;
   assign exp_we    = add_we || (cmd.apply_wr && periodic);
   assign wr_addr   = cmd.add_commit ? free_idx_ff : order_slot;
   assign exp_wdata = cmd.add_commit ? add_exp_ff : rearm_val;

   always_ff @(posedge clock) begin
      if (exp_we) exp_mem[wr_addr] <= exp_wdata;
      if (add_we) begin
         ivl_mem[wr_addr] <= add_ivl_ff;
         tag_mem[wr_addr] <= tag_ctr_ff;
      end
      exp_rd_ff <= exp_mem[rd_addr];
      ivl_rd_ff <= ivl_mem[rd_addr];
      tag_rd_ff <= tag_mem[rd_addr];
   end

   always_comb begin
      valid_in = valid_ff;
      if (add_we) valid_in[free_idx_ff] = 1'b1;
      if (cmd.cancel_check && hit) valid_in[cidx] = 1'b0;
      if (cmd.apply_wr && !periodic) valid_in[order_slot] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         tag_ctr_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (add_we) tag_ctr_ff <= tag_ctr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tick_init) begin
         chosen_ff <= '0;
      end else if (cmd.pick) begin
         chosen_ff[best_idx_ff] <= 1'b1;
      end
      if (cmd.cancel_check) hit_ff <= hit;
   end

   // Scanner control.
   assign scan_start = cmd.scan_req && !scan_run_ff && !pv_ff;
   assign scan_done  = pv_ff && (pidx_ff == LAST_SLOT);

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_run_ff <= 1'b0;
         pv_ff       <= 1'b0;
      end else begin
         if (scan_start) begin
            scan_run_ff <= 1'b1;
         end else if (scan_run_ff && scan_idx_ff == LAST_SLOT) begin
            scan_run_ff <= 1'b0;
         end
         pv_ff <= scan_run_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (scan_start) begin
         scan_idx_ff <= '0;
      end else if (scan_run_ff) begin
         scan_idx_ff <= scan_idx_ff + 1'b1;
      end
      pidx_ff <= scan_idx_ff;
   end

   // A due scan looks only at unchosen slots at or before now. Ascending
   // order with a strict compare gives ties to the lower slot.
   assign cand = valid_ff[pidx_ff] &&
                 (!cmd.scan_due || (!chosen_ff[pidx_ff] && exp_rd_ff <= now_ff));

   always_comb begin
      best_any_in = best_any_ff;
      best_val_in = best_val_ff;
      best_idx_in = best_idx_ff;
      free_any_in = free_any_ff;
      free_idx_in = free_idx_ff;
      if (scan_start) begin
         best_any_in = 1'b0;
         free_any_in = 1'b0;
      end else if (pv_ff) begin
         if (cand && (!best_any_ff || exp_rd_ff < best_val_ff)) begin
            best_any_in = 1'b1;
            best_val_in = exp_rd_ff;
            best_idx_in = pidx_ff;
         end
         if (!valid_ff[pidx_ff] && !free_any_ff) begin
            free_any_in = 1'b1;
            free_idx_in = pidx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_any_ff <= 1'b0;
         free_any_ff <= 1'b0;
      end else begin
         best_any_ff <= best_any_in;
         free_any_ff <= free_any_in;
      end
      best_val_ff <= best_val_in;
      best_idx_ff <= best_idx_in;
      free_idx_ff <= free_idx_in;
   end

   // Order list and counters.
   always_ff @(posedge clock) begin
      if (cmd.pick) order_ff[n_ff[tqm_pkg::ORDER_W-1:0]] <= best_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff <= '0;
         k_ff <= '0;
      end else begin
         if (cmd.tick_init) begin
            n_ff <= '0;
         end else if (cmd.pick) begin
            n_ff <= n_ff + 1'b1;
         end
         if (cmd.k_clear) begin
            k_ff <= '0;
         end else if (cmd.k_inc) begin
            k_ff <= k_ff + 1'b1;
         end
      end
   end

   // Result register.
   logic                              rsp_valid_ff;
   logic [tqm_pkg::STATUS_W-1:0]      status_ff, status_in;
   logic [tqm_pkg::SLOT_OUT_W-1:0]    slot_ff, slot_in;
   logic [tqm_pkg::TAG_W-1:0]         tag_ff, tag_in;
   logic                              rearmed_ff, rearmed_in;
   logic                              early_ff, early_in;
   logic                              nvalid_ff, nvalid_in;
   logic [tqm_pkg::TIME_W-1:0]        nexp_ff, nexp_in;
   logic                              last_ff, last_in;

   always_comb begin
      status_in  = tqm_pkg::ST_TICK_DONE;
      slot_in    = '0;
      tag_in     = '0;
      rearmed_in = 1'b0;
      early_in   = 1'b0;
      last_in    = 1'b1;
      nvalid_in  = best_any_ff;
      nexp_in    = best_any_ff ? best_val_ff : '0;
      case (cmd.rsp_kind)
         tqm_pkg::RSP_ADD: begin
            if (free_any_ff) begin
               status_in = tqm_pkg::ST_ADDED;
               slot_in   = tqm_pkg::SLOT_OUT_W'(free_idx_ff);
               tag_in    = tag_ctr_ff;
               early_in  = add_early;
               nvalid_in = 1'b1;
               nexp_in   = add_next;
            end else begin
               status_in = tqm_pkg::ST_FULL;
            end
         end
         tqm_pkg::RSP_CANCEL: begin
            status_in = hit_ff ? tqm_pkg::ST_CANCELLED : tqm_pkg::ST_NOT_FOUND;
            slot_in   = cslot_ff;
            tag_in    = ctag_ff;
         end
         tqm_pkg::RSP_EXPIRED: begin
            status_in  = tqm_pkg::ST_EXPIRED;
            slot_in    = tqm_pkg::SLOT_OUT_W'(order_slot);
            tag_in     = tag_rd_ff;
            rearmed_in = periodic;
            last_in    = 1'b0;
         end
         default: begin
            status_in = tqm_pkg::ST_TICK_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         status_ff  <= status_in;
         slot_ff    <= slot_in;
         tag_ff     <= tag_in;
         rearmed_ff <= rearmed_in;
         early_ff   <= early_in;
         nvalid_ff  <= nvalid_in;
         nexp_ff    <= nexp_in;
         last_ff    <= last_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_slot             = slot_ff;
   assign rsp_tag              = tag_ff;
   assign rsp_rearmed          = rearmed_ff;
   assign rsp_earliest_changed = early_ff;
   assign rsp_next_valid       = nvalid_ff;
   assign rsp_next_expiry      = nexp_ff;
   assign rsp_last             = last_ff;

   always_comb begin
      sts           = '0;
      sts.cmd       = cmd_ff;
      sts.scan_done = scan_done;
      sts.due_found = best_any_ff;
      sts.n_zero    = (n_ff == '0);
      sts.n_max     = (n_ff == tqm_pkg::NCNT_W'(tqm_pkg::MAX_EXPIRED));
      sts.k_last    = ((tqm_pkg::NCNT_W'(k_ff) + tqm_pkg::NCNT_W'(1)) == n_ff);
      sts.out_free  = !rsp_valid_ff || rsp_ready;
   end

endmodule

`default_nettype wire

// ----- hdl/tqm_checker.sv -----
// Port-level checks of the timer queue manager and their binding.
`default_nettype none

module tqm_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_ready,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic [tqm_pkg::STATUS_W-1:0]    rsp_status,
   input wire logic                            rsp_rearmed,
   input wire logic                            rsp_earliest_changed,
   input wire logic                            rsp_next_valid,
   input wire logic                            rsp_last
);

   // A stalled result item stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   // Only expired items are followed by more items of the same command.
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_status != tqm_pkg::ST_EXPIRED)))
      else $error("last flag does not match the result kind");

   // A new earliest expiry comes only from a successful add, which leaves
   // a timer pending.
   a_early_add: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_earliest_changed |->
         (rsp_status == tqm_pkg::ST_ADDED) && rsp_next_valid)
      else $error("earliest change outside an add");

   // Re-arming happens only on expired items and leaves a timer pending.
   a_rearm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rearmed |->
         (rsp_status == tqm_pkg::ST_EXPIRED) && rsp_next_valid)
      else $error("re-arm flag on a wrong result");

   // No new command is taken in the cycle after one was accepted.
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("command accepted while busy");

endmodule

bind timer_queue_manager_unit tqm_checker u_tqm_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_ready            (req_ready),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_status           (rsp_status),
   .rsp_rearmed          (rsp_rearmed),
   .rsp_earliest_changed (rsp_earliest_changed),
   .rsp_next_valid       (rsp_next_valid),
   .rsp_last             (rsp_last)
);

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the timer queue manager unit.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // The block is built with its default table of sixteen slots.
   localparam int NUM_SLOTS = 16;
   localparam logic [tqm_pkg::TIME_W-1:0] TIME_MAX = {tqm_pkg::TIME_W{1'b1}};
   // The command field has one code that the block ignores.
   localparam tqm_pkg::cmd_type CMD_UNUSED = 2'd3;

   // A tick with all sixteen slots due runs a scan for each of them, and every
   // result may wait out a receiver stall, so the limit is kept generous.
   localparam int CYCLE_LIMIT   = 1000000;
   // Quiet time at the end, before the count of owed results is checked.
   localparam int SETTLE_CYCLES = 200;
   // Length of a deliberate receiver hold-off.
   localparam int HOLD_CYCLES   = 300;
   localparam int MAX_REPORTS   = 10;

   // One command as it is offered on the req_ channel.
   typedef struct packed {
      tqm_pkg::cmd_type                   command;
      logic [tqm_pkg::TIME_W-1:0]         expiry_time;
      logic [tqm_pkg::IVL_W-1:0]          repeat_interval;
      logic [tqm_pkg::SLOT_OUT_W-1:0]     cancel_slot;
      logic [tqm_pkg::TAG_W-1:0]          cancel_tag;
      logic [tqm_pkg::TIME_W-1:0]         now_time;
   } timer_cmd_type;

   // One result as it leaves on the rsp_ channel.
   typedef struct packed {
      tqm_pkg::status_type                status;
      logic [tqm_pkg::SLOT_OUT_W-1:0]     slot;
      logic [tqm_pkg::TAG_W-1:0]          tag;
      logic                               rearmed;
      logic                               earliest_changed;
      logic                               next_valid;
      logic [tqm_pkg::TIME_W-1:0]         next_expiry;
      logic                               last;
   } timer_rsp_type;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   tqm_pkg::cmd_type                  req_command;
   logic [tqm_pkg::TIME_W-1:0]        req_expiry_time;
   logic [tqm_pkg::IVL_W-1:0]         req_repeat_interval;
   logic [tqm_pkg::SLOT_OUT_W-1:0]    req_cancel_slot;
   logic [tqm_pkg::TAG_W-1:0]         req_cancel_tag;
   logic [tqm_pkg::TIME_W-1:0]        req_now_time;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   tqm_pkg::status_type               rsp_status;
   logic [tqm_pkg::SLOT_OUT_W-1:0]    rsp_slot;
   logic [tqm_pkg::TAG_W-1:0]         rsp_tag;
   logic                              rsp_rearmed;
   logic                              rsp_earliest_changed;
   logic                              rsp_next_valid;
   logic [tqm_pkg::TIME_W-1:0]        rsp_next_expiry;
   logic                              rsp_last;

   // Our own copy of the timer table, updated as each command is accepted.
   logic                              tbl_valid    [NUM_SLOTS];
   logic [tqm_pkg::TIME_W-1:0]        tbl_expiry   [NUM_SLOTS];
   logic [tqm_pkg::IVL_W-1:0]         tbl_interval [NUM_SLOTS];
   logic [tqm_pkg::TAG_W-1:0]         tbl_tag      [NUM_SLOTS];
   logic [tqm_pkg::TAG_W-1:0]         next_tag;

   // Results still owed by the block, oldest first.
   timer_rsp_type                     awaited_results [$];

   // Notion of the current time that the random traffic moves forward.
   logic [tqm_pkg::TIME_W-1:0]        wall_ms;

   int                      tx_idle_pct  = 0;
   int                      rx_stall_pct = 0;
   int                      hold_requests = 0;
   int                      holds_served  = 0;
   int                      hold_left     = 0;
   int unsigned             cycle_count   = 0;

   int                      mismatches      = 0;
   int                      commands_sent   = 0;
   int                      ignored_sent    = 0;
   int                      results_checked = 0;
   int                      expired_seen    = 0;
   int                      rearmed_seen    = 0;
   int                      full_seen       = 0;
   int                      cancelled_seen  = 0;

   timer_queue_manager_unit dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_command          (req_command),
      .req_expiry_time      (req_expiry_time),
      .req_repeat_interval  (req_repeat_interval),
      .req_cancel_slot      (req_cancel_slot),
      .req_cancel_tag       (req_cancel_tag),
      .req_now_time         (req_now_time),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_slot             (rsp_slot),
      .rsp_tag              (rsp_tag),
      .rsp_rearmed          (rsp_rearmed),
      .rsp_earliest_changed (rsp_earliest_changed),
      .rsp_next_valid       (rsp_next_valid),
      .rsp_next_expiry      (rsp_next_expiry),
      .rsp_last             (rsp_last)
   );

   always #5 clock = ~clock;

   // Run limit. A run that gets here has hung somewhere, which is a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d results outstanding.",
                  cycle_count, awaited_results.size());
         $display("timer_queue_manager_unit: mismatch");
         $finish;
      end
   end

   // Receiver. A test asks for a long hold-off by bumping hold_requests; the
   // hold is counted here, so the sender keeps offering items meanwhile. Outside
   // a hold the receiver stalls at random at the rate of the current phase.
   always @(posedge clock) begin
      if (hold_requests != holds_served) begin
         holds_served <= hold_requests;
         hold_left    <= HOLD_CYCLES;
         rsp_ready    <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // Earliest expiry among the live slots; returns whether any slot is live.
   function automatic bit earliest_pending(output logic [tqm_pkg::TIME_W-1:0] when);
      bit found;
      found = 1'b0;
      when  = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (tbl_valid[i] && (!found || tbl_expiry[i] < when)) begin
            when  = tbl_expiry[i];
            found = 1'b1;
         end
      end
      return found;
   endfunction

   // Applies one accepted command to our table and queues the results it must
   // produce. Every result of a command reports the earliest pending expiry as
   // it stands once the whole command has been applied.
   function automatic void apply_timer_command(input timer_cmd_type c);
      timer_rsp_type                 batch [$];
      timer_rsp_type                 r;
      logic [tqm_pkg::TIME_W-1:0]    earliest;
      logic [tqm_pkg::TIME_W:0]      rearm_at;
      bit                            any_pending;
      bit                            fired [NUM_SLOTS];
      int                            free_slot;
      int                            best;

      case (c.command)
         tqm_pkg::CMD_ADD: begin
            r = '0;
            any_pending = earliest_pending(earliest);
            free_slot = -1;
            for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
               if (!tbl_valid[i]) free_slot = i;
            end
            if (free_slot < 0) begin
               r.status = tqm_pkg::ST_FULL;
            end else begin
               tbl_valid[free_slot]    = 1'b1;
               tbl_expiry[free_slot]   = c.expiry_time;
               tbl_interval[free_slot] = c.repeat_interval;
               tbl_tag[free_slot]      = next_tag;
               next_tag                = next_tag + 1'b1;
               r.status           = tqm_pkg::ST_ADDED;
               r.slot             = tqm_pkg::SLOT_OUT_W'(free_slot);
               r.tag              = tbl_tag[free_slot];
               r.earliest_changed = !any_pending || (c.expiry_time < earliest);
            end
            batch.push_back(r);
         end
         tqm_pkg::CMD_CANCEL: begin
            r = '0;
            r.status = tqm_pkg::ST_NOT_FOUND;
            if (tbl_valid[c.cancel_slot] && tbl_tag[c.cancel_slot] == c.cancel_tag) begin
               tbl_valid[c.cancel_slot] = 1'b0;
               r.status = tqm_pkg::ST_CANCELLED;
            end
            r.slot = c.cancel_slot;
            r.tag  = c.cancel_tag;
            batch.push_back(r);
         end
         tqm_pkg::CMD_TICK: begin
            foreach (fired[i]) fired[i] = 1'b0;
            // Pick due slots one at a time, earliest first, lower slot on ties.
            // A slot is settled as soon as it is picked; picked slots take no
            // further part in the search, so this matches picking all first.
            repeat (tqm_pkg::MAX_EXPIRED) begin
               best = -1;
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  if (tbl_valid[i] && !fired[i] && tbl_expiry[i] <= c.now_time &&
                      (best < 0 || tbl_expiry[i] < tbl_expiry[best]))
                     best = i;
               end
               if (best >= 0) begin
                  fired[best] = 1'b1;
                  r = '0;
                  r.status  = tqm_pkg::ST_EXPIRED;
                  r.slot    = tqm_pkg::SLOT_OUT_W'(best);
                  r.tag     = tbl_tag[best];
                  r.rearmed = (tbl_interval[best] != '0);
                  if (r.rearmed) begin
                     // Re-arm time saturates at the top of the time range.
                     rearm_at = c.now_time + tbl_interval[best];
                     tbl_expiry[best] = (rearm_at > TIME_MAX) ? TIME_MAX
                                        : rearm_at[tqm_pkg::TIME_W-1:0];
                  end else begin
                     tbl_valid[best] = 1'b0;
                  end
                  batch.push_back(r);
               end
            end
            r = '0;
            r.status = tqm_pkg::ST_TICK_DONE;
            batch.push_back(r);
         end
         default: ;
      endcase

      any_pending = earliest_pending(earliest);
      foreach (batch[k]) begin
         batch[k].next_valid  = any_pending;
         batch[k].next_expiry = earliest;
         batch[k].last        = (k == batch.size() - 1);
         awaited_results.push_back(batch[k]);
      end
   endfunction

   function automatic string format_result(input timer_rsp_type r);
      return $sformatf("status=%0d slot=%0d tag=%h rearmed=%0b changed=%0b next=%0b/%h last=%0b",
                       r.status, r.slot, r.tag, r.rearmed, r.earliest_changed,
                       r.next_valid, r.next_expiry, r.last);
   endfunction

   function automatic void note_mismatch(input string what, input timer_rsp_type want,
                                         input timer_rsp_type seen);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("[%0t] %s", $realtime, what);
         $display("   expected %s", format_result(want));
         $display("   actual   %s", format_result(seen));
      end
   endfunction

   // Result checker: every accepted item is compared with the oldest result
   // still owed. The comparison covers every field of the result at once.
   always @(posedge clock) begin : result_check
      timer_rsp_type seen;
      timer_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.status           = rsp_status;
         seen.slot             = rsp_slot;
         seen.tag              = rsp_tag;
         seen.rearmed          = rsp_rearmed;
         seen.earliest_changed = rsp_earliest_changed;
         seen.next_valid       = rsp_next_valid;
         seen.next_expiry      = rsp_next_expiry;
         seen.last             = rsp_last;
         results_checked++;
         if (seen.status == tqm_pkg::ST_EXPIRED) expired_seen++;
         if (seen.status == tqm_pkg::ST_EXPIRED && seen.rearmed) rearmed_seen++;
         if (seen.status == tqm_pkg::ST_FULL) full_seen++;
         if (seen.status == tqm_pkg::ST_CANCELLED) cancelled_seen++;
         if (awaited_results.size() == 0) begin
            note_mismatch("result arrived with none outstanding", '0, seen);
         end else begin
            want = awaited_results.pop_front();
            if (seen !== want) note_mismatch("result differs", want, seen);
         end
      end
   end

   // Offers one item, after a random idle gap at the current sender rate, and
   // returns at the edge where it is taken. Valid is left high, so a following
   // item without a gap goes out back to back.
   task automatic send_item(input timer_cmd_type c);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_command         <= c.command;
      req_expiry_time     <= c.expiry_time;
      req_repeat_interval <= c.repeat_interval;
      req_cancel_slot     <= c.cancel_slot;
      req_cancel_tag      <= c.cancel_tag;
      req_now_time        <= c.now_time;
      do @(posedge clock); while (!req_ready);
      apply_timer_command(c);
      if (c.command == CMD_UNUSED) ignored_sent++;
      else commands_sent++;
   endtask

   // Sender goes quiet until every owed result has been received.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_results.size() != 0);
   endtask

   function automatic timer_cmd_type blank_cmd(input tqm_pkg::cmd_type cmd);
      timer_cmd_type c;
      c = '0;
      c.command = cmd;
      return c;
   endfunction

   function automatic logic [tqm_pkg::TIME_W-1:0] random_time();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[tqm_pkg::TIME_W-1:0];
   endfunction

   // Mostly well-formed traffic around the moving wall time: adds a little in
   // the future, cancels of live timers with their right tag, ticks that step
   // time forward. The rest is noise: far times, stale tags, random slots and
   // the ignored command code. Unused fields always carry random bits.
   function automatic timer_cmd_type random_timer_cmd();
      timer_cmd_type c;
      int            pick;
      int            sel;
      int            live [$];
      c.expiry_time     = random_time();
      c.repeat_interval = $urandom();
      c.cancel_slot     = tqm_pkg::SLOT_OUT_W'($urandom_range(NUM_SLOTS - 1));
      c.cancel_tag      = tqm_pkg::TAG_W'($urandom());
      c.now_time        = random_time();
      pick = $urandom_range(99);
      if (pick < 40) begin
         c.command = tqm_pkg::CMD_ADD;
         if ($urandom_range(9) != 0) c.expiry_time = wall_ms + $urandom_range(200);
         sel = $urandom_range(9);
         if (sel >= 5) c.repeat_interval = '0;
         else if (sel >= 1) c.repeat_interval = $urandom_range(150, 1);
      end else if (pick < 65) begin
         c.command = tqm_pkg::CMD_CANCEL;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (tbl_valid[i]) live.push_back(i);
         end
         sel = $urandom_range(99);
         if (live.size() > 0 && sel < 85) begin
            c.cancel_slot = tqm_pkg::SLOT_OUT_W'(live[$urandom_range(live.size() - 1)]);
            c.cancel_tag  = tbl_tag[c.cancel_slot];
            // A stale handle: right slot, tag off by one bit.
            if (sel >= 75) c.cancel_tag[$urandom_range(tqm_pkg::TAG_W - 1)] ^= 1'b1;
         end
      end else if (pick < 96) begin
         c.command = tqm_pkg::CMD_TICK;
         if ($urandom_range(19) != 0) begin
            // Now and then a big step lets many timers fall due at once.
            wall_ms = wall_ms + (($urandom_range(9) == 0) ? $urandom_range(2000)
                                                          : $urandom_range(120));
            c.now_time = wall_ms;
         end
      end else begin
         c.command = CMD_UNUSED;
      end
      return c;
   endfunction

   // Directed cases: empty-table tick, the ignored code, a cancel with a wrong
   // tag, a cancel of a free slot, a good cancel, a full table and a rejected
   // add, a tick with ties in expiry, and ticks at the top of the time range
   // where periodic re-arm saturates.
   task automatic test_directed_cases();
      timer_cmd_type c;
      tx_idle_pct = 0;
      rx_stall_pct <= 0;

      c = blank_cmd(tqm_pkg::CMD_TICK);
      send_item(c);
      c = random_timer_cmd();
      c.command = CMD_UNUSED;
      send_item(c);
      c = blank_cmd(tqm_pkg::CMD_ADD);
      send_item(c);
      c = blank_cmd(tqm_pkg::CMD_CANCEL);
      c.cancel_tag = tbl_tag[0] + 1'b1;
      send_item(c);
      c = blank_cmd(tqm_pkg::CMD_CANCEL);
      c.cancel_slot = tqm_pkg::SLOT_OUT_W'(5);
      send_item(c);
      c = blank_cmd(tqm_pkg::CMD_CANCEL);
      c.cancel_tag = tbl_tag[0];
      send_item(c);

      // Fill the table: one timer at the top of time with the longest period,
      // one at time zero, the rest in three groups of equal expiry, some of
      // them periodic.
      for (int i = 0; i < NUM_SLOTS; i++) begin
         c = blank_cmd(tqm_pkg::CMD_ADD);
         if (i == 0) begin
            c.expiry_time     = TIME_MAX;
            c.repeat_interval = '1;
         end else if (i == NUM_SLOTS - 1) begin
            c.expiry_time = '0;
         end else begin
            c.expiry_time     = tqm_pkg::TIME_W'(100 + (i % 3) * 20);
            c.repeat_interval = tqm_pkg::IVL_W'((i % 4 == 1) ? 30 : 0);
         end
         send_item(c);
      end
      c = blank_cmd(tqm_pkg::CMD_ADD);
      c.expiry_time     = tqm_pkg::TIME_W'(5);
      c.repeat_interval = tqm_pkg::IVL_W'(7);
      send_item(c);

      c = blank_cmd(tqm_pkg::CMD_TICK);
      c.now_time = tqm_pkg::TIME_W'(120);
      send_item(c);
      c.now_time = TIME_MAX;
      send_item(c);
      send_item(c);
      wait_drained();
   endtask

   task automatic test_random_traffic(input int count, input int tx_pct, input int rx_pct);
      timer_cmd_type c;
      int            sent;
      tx_idle_pct = tx_pct;
      rx_stall_pct <= rx_pct;
      sent = 0;
      while (sent < count) begin
         c = random_timer_cmd();
         send_item(c);
         if (c.command != CMD_UNUSED) sent++;
      end
      wait_drained();
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering
   // commands back to back, so the result register fills and the block stops
   // taking commands. The second hold lands on a tick with several results.
   task automatic test_backpressure();
      timer_cmd_type c;
      tx_idle_pct = 0;
      rx_stall_pct <= 0;
      hold_requests <= hold_requests + 1;
      for (int i = 0; i < 4; i++) begin
         c = blank_cmd(tqm_pkg::CMD_ADD);
         c.expiry_time     = wall_ms + i;
         c.repeat_interval = tqm_pkg::IVL_W'((i % 2 != 0) ? 25 : 0);
         send_item(c);
      end
      c = blank_cmd(tqm_pkg::CMD_TICK);
      wall_ms = wall_ms + 10;
      c.now_time = wall_ms;
      send_item(c);
      wait_drained();

      hold_requests <= hold_requests + 1;
      c = blank_cmd(tqm_pkg::CMD_TICK);
      wall_ms = wall_ms + 100;
      c.now_time = wall_ms;
      send_item(c);
      c = blank_cmd(tqm_pkg::CMD_ADD);
      c.expiry_time = wall_ms + 50;
      send_item(c);
      wait_drained();
   endtask

   initial begin
      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_command         <= tqm_pkg::CMD_ADD;
      req_expiry_time     <= '0;
      req_repeat_interval <= '0;
      req_cancel_slot     <= '0;
      req_cancel_tag      <= '0;
      req_now_time        <= '0;
      foreach (tbl_valid[i]) begin
         tbl_valid[i]    = 1'b0;
         tbl_expiry[i]   = '0;
         tbl_interval[i] = '0;
         tbl_tag[i]      = '0;
      end
      next_tag = '0;
      wall_ms  = tqm_pkg::TIME_W'(1000);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      // Random phases: no idling, idle sender, stalling receiver, then both.
      test_random_traffic(45, 0, 0);
      test_random_traffic(45, 59, 0);
      test_random_traffic(45, 0, 59);
      test_random_traffic(45, 20, 20);
      test_backpressure();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (awaited_results.size() != 0) begin
         mismatches += awaited_results.size();
         $display("%0d expected results never arrived.", awaited_results.size());
      end

      $display("Covered %0d commands plus %0d ignored codes; %0d results checked.",
               commands_sent, ignored_sent, results_checked);
      $display("Seen: %0d expirations (%0d re-armed), %0d cancels, %0d full-table rejects.",
               expired_seen, rearmed_seen, cancelled_seen, full_seen);
      if (mismatches == 0) begin
         $display("timer_queue_manager_unit: match");
      end else begin
         $display("%0d mismatches in total.", mismatches);
         $display("timer_queue_manager_unit: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire
